// ----- rtl/rgb_to_yuv420_converter_top_assert.svh -----
// Assertion macros for the RGB to YUV 4:2:0 converter top level.
`ifndef RGB_TO_YUV420_CONVERTER_TOP_ASSERT_SVH
`define RGB_TO_YUV420_CONVERTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RGBYUV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rgbyuv assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RGBYUV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rgbyuv assertion failed");

`endif

// ----- rtl/rgbyuv_pkg.sv -----
// Shared types, constants and color math for the RGB to YUV 4:2:0 converter.
`timescale 1ns / 1ps

package rgbyuv_pkg;

    localparam int PIX_W       = 8;
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int MAX_DIM_DEF = 4096;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 13'd736;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd576;

    // 16-bit sums hold every intermediate value below
    localparam int SUM_W = 16;

    localparam logic [SUM_W-1:0] K_Y_R     = 16'd66;
    localparam logic [SUM_W-1:0] K_Y_G     = 16'd129;
    localparam logic [SUM_W-1:0] K_Y_B     = 16'd25;
    localparam logic [SUM_W-1:0] K_C_MAIN  = 16'd112;
    localparam logic [SUM_W-1:0] K_CR_G    = 16'd94;
    localparam logic [SUM_W-1:0] K_CR_B    = 16'd18;
    localparam logic [SUM_W-1:0] K_CB_R    = 16'd38;
    localparam logic [SUM_W-1:0] K_CB_G    = 16'd74;
    localparam logic [SUM_W-1:0] K_ROUND   = 16'd128;
    localparam logic [SUM_W-1:0] K_BIAS    = 16'd32768;
    localparam logic [PIX_W-1:0] K_Y_OFS   = 8'd16;

    typedef struct packed {
        logic even_col;
        logic odd_row;
        logic eol;
        logic eof;
    } t_pos_flags;

    function automatic logic [PIX_W-1:0] luma_of(
        input logic [PIX_W-1:0] r,
        input logic [PIX_W-1:0] g,
        input logic [PIX_W-1:0] b
    );
        logic [SUM_W-1:0] s;
        s = K_Y_R * SUM_W'(r) + K_Y_G * SUM_W'(g) + K_Y_B * SUM_W'(b) + K_ROUND;
        return s[SUM_W-1:8] + K_Y_OFS;
    endfunction

    // floor((pos - neg + 128) / 256) + 128, mod 256; bias keeps it unsigned
    function automatic logic [PIX_W-1:0] chroma_of(
        input logic [SUM_W-1:0] pos,
        input logic [SUM_W-1:0] neg
    );
        logic [SUM_W-1:0] t;
        t = pos + K_ROUND + K_BIAS - neg;
        return t[SUM_W-1:8];
    endfunction

endpackage

// ----- rtl/rgbyuv_pos.sv -----
// Pixel position tracking: dimension registers, column and row counters.
`timescale 1ns / 1ps

module rgbyuv_pos #(
    parameter int MAX_DIMENSION = rgbyuv_pkg::MAX_DIM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rgbyuv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rgbyuv_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                                i_step,
    output rgbyuv_pkg::t_pos_flags              o_flags
);
    import rgbyuv_pkg::*;

    localparam int CW = $clog2(MAX_DIMENSION);
    localparam int DW = (CFG_W > CW + 1) ? CFG_W : CW + 1;

    logic [CFG_W-1:0] r_line_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [CW-1:0]    r_col;
    logic [CW-1:0]    r_row;
    logic [CW-1:0]    n_col;
    logic [CW-1:0]    n_row;
    logic [DW-1:0]    w_eff;
    logic [DW-1:0]    h_eff;

    always_comb begin
        w_eff = DW'(r_line_width);
        if (r_line_width == '0) begin
            w_eff = DW'(1);
        end else if (DW'(r_line_width) > DW'(MAX_DIMENSION)) begin
            w_eff = DW'(MAX_DIMENSION);
        end
        h_eff = DW'(r_frame_height);
        if (r_frame_height == '0) begin
            h_eff = DW'(1);
        end else if (DW'(r_frame_height) > DW'(MAX_DIMENSION)) begin
            h_eff = DW'(MAX_DIMENSION);
        end
    end

    always_comb begin
        o_flags.even_col = ~r_col[0];
        o_flags.odd_row  = r_row[0];
        o_flags.eol      = (DW'(r_col) + DW'(1)) >= w_eff;
        o_flags.eof      = o_flags.eol && ((DW'(r_row) + DW'(1)) >= h_eff);
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_step) begin
            if (o_flags.eol) begin
                n_col = '0;
                n_row = o_flags.eof ? '0 : r_row + CW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LINE_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_col          <= '0;
            r_row          <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data;
                    CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- rtl/rgbyuv_csc.sv -----
// Color space conversion: BT.601 integer luma and row-selected chroma.
`timescale 1ns / 1ps

module rgbyuv_csc (
    input  logic [rgbyuv_pkg::PIX_W-1:0]  i_red,
    input  logic [rgbyuv_pkg::PIX_W-1:0]  i_green,
    input  logic [rgbyuv_pkg::PIX_W-1:0]  i_blue,
    input  rgbyuv_pkg::t_pos_flags        i_flags,
    output logic [rgbyuv_pkg::PIX_W-1:0]  o_luma,
    output logic [rgbyuv_pkg::PIX_W-1:0]  o_chroma
);
    import rgbyuv_pkg::*;

    logic [SUM_W-1:0] pos_sum;
    logic [SUM_W-1:0] neg_sum;

    always_comb begin
        if (i_flags.odd_row) begin
            pos_sum = K_C_MAIN * SUM_W'(i_blue);
            neg_sum = K_CB_R * SUM_W'(i_red) + K_CB_G * SUM_W'(i_green);
        end else begin
            pos_sum = K_C_MAIN * SUM_W'(i_red);
            neg_sum = K_CR_G * SUM_W'(i_green) + K_CR_B * SUM_W'(i_blue);
        end
    end

    assign o_luma   = luma_of(i_red, i_green, i_blue);
    assign o_chroma = i_flags.even_col ? chroma_of(pos_sum, neg_sum) : '0;

endmodule

// ----- rtl/rgb_to_yuv420_converter_top.sv -----
// Top level of the RGB to YUV 4:2:0 pixel converter.
`timescale 1ns / 1ps
// Usage:
//   Pixels enter on the input channel (i_in_valid / o_in_ready) in raster
//   order, one RGB triple per transaction. Every pixel gives one output
//   transaction (o_out_valid / i_out_ready) with its luma; even columns
//   also carry a chroma sample, plane 0 on even rows and plane 1 on odd
//   rows, with end_of_line and end_of_frame markers.
//   Line width and frame height are written through the config channel
//   (index 0 and 1); o_cfg_ready is always high. Write them while idle.
//   Each pixel passes through the input register, then the result
//   register. Throughput: one pixel per cycle while i_out_ready is high.
//   A stalled receiver holds the result register; the input register
//   keeps taking one more pixel, then o_in_ready drops until the output
//   drains. Ready paths are combinational from i_out_ready.
//   Reset (synchronous, active low) empties both stages, zeroes the
//   column and row counters and restores width 736 and height 576.

module rgb_to_yuv420_converter_top #(
    parameter int MAX_DIMENSION = rgbyuv_pkg::MAX_DIM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rgbyuv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rgbyuv_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [rgbyuv_pkg::PIX_W-1:0]        i_red,
    input  logic [rgbyuv_pkg::PIX_W-1:0]        i_green,
    input  logic [rgbyuv_pkg::PIX_W-1:0]        i_blue,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [rgbyuv_pkg::PIX_W-1:0]        o_luma,
    output logic [rgbyuv_pkg::PIX_W-1:0]        o_chroma,
    output logic                                o_chroma_valid,
    output logic                                o_chroma_plane,
    output logic                                o_end_of_line,
    output logic                                o_end_of_frame
);
    import rgbyuv_pkg::*;

    t_pos_flags       w_pos;
    logic             in_fire;
    logic             s2_ready;

    logic             r_s1_valid;
    logic [PIX_W-1:0] r_s1_red;
    logic [PIX_W-1:0] r_s1_green;
    logic [PIX_W-1:0] r_s1_blue;
    t_pos_flags       r_s1_flags;

    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_luma;
    logic [PIX_W-1:0] r_out_chroma;
    t_pos_flags       r_out_flags;

    logic [PIX_W-1:0] csc_luma;
    logic [PIX_W-1:0] csc_chroma;

    assign o_cfg_ready = 1'b1;
    assign s2_ready    = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_s1_valid || s2_ready;
    assign in_fire     = i_in_valid && o_in_ready;

    rgbyuv_pos #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (in_fire),
        .o_flags     (w_pos)
    );

    rgbyuv_csc u_csc (
        .i_red    (r_s1_red),
        .i_green  (r_s1_green),
        .i_blue   (r_s1_blue),
        .i_flags  (r_s1_flags),
        .o_luma   (csc_luma),
        .o_chroma (csc_chroma)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_red   <= i_red;
            r_s1_green <= i_green;
            r_s1_blue  <= i_blue;
            r_s1_flags <= w_pos;
        end
        if (s2_ready && r_s1_valid) begin
            r_out_luma   <= csc_luma;
            r_out_chroma <= csc_chroma;
            r_out_flags  <= r_s1_flags;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_luma         = r_out_luma;
    assign o_chroma       = r_out_chroma;
    assign o_chroma_valid = r_out_flags.even_col;
    assign o_chroma_plane = r_out_flags.odd_row;
    assign o_end_of_line  = r_out_flags.eol;
    assign o_end_of_frame = r_out_flags.eof;

`include "rgb_to_yuv420_converter_top_assert.svh"

    `RGBYUV_ASSERT_NOW(a_eof_ends_line, o_out_valid && o_end_of_frame, o_end_of_line)
    `RGBYUV_ASSERT_NOW(a_chroma_zero_odd_col, o_out_valid && !o_chroma_valid, o_chroma == '0)
    `RGBYUV_ASSERT_NOW(a_luma_range, o_out_valid, o_luma >= 8'd16 && o_luma <= 8'd235)
    `RGBYUV_ASSERT_NEXT(a_col_parity_flips, in_fire && !w_pos.eol && w_pos.even_col,
                        !w_pos.even_col)

endmodule
